[src/euv_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euv_pkg
// Shared constants, register map and lane interface types for the encoder
// turn-unwrap and velocity block.
// ---------------------------------------------------------------------------
package euv_pkg;

    // Datapath widths
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 16;
    localparam int TURN_BITS     = 16;
    localparam int POS_BITS      = 32;
    localparam int STAMP_BITS    = 32;
    localparam int INTERVAL_BITS = 16;

    // Fraction divider: quotient holds a full turn, one bit per step
    localparam int FRAC_W     = FRACTION_BITS + 1;
    localparam int FRAC_STEPS = FRACTION_BITS + 1;
    localparam int FRAC_CNT_W = $clog2(FRAC_STEPS);

    // Velocity: |diff| * 1000 / dt
    localparam int RATE_SCALE = 1000;
    localparam int DIFF_W     = POS_BITS + 1;
    localparam int MAG_W      = DIFF_W + $clog2(RATE_SCALE);
    localparam int VDIV_CNT_W = $clog2(MAG_W);

    // Configuration port
    localparam int REG_COUNT = 7;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(REG_COUNT * 4);
    localparam int IDX_W     = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_LOWER_RIGHT  = 3'd0,
        REG_UPPER_RIGHT  = 3'd1,
        REG_LOWER_LEFT   = 3'd2,
        REG_UPPER_LEFT   = 3'd3,
        REG_REVERSE_RIGHT = 3'd4,
        REG_REVERSE_LEFT = 3'd5,
        REG_MIN_INTERVAL = 3'd6
    } t_reg_idx;

    // Reset values
    localparam logic [SAMPLE_BITS-1:0]   RST_LOWER    = '0;
    localparam logic [SAMPLE_BITS-1:0]   RST_UPPER    = SAMPLE_BITS'(1023);
    localparam logic                     RST_REV_RIGHT = 1'b0;
    localparam logic                     RST_REV_LEFT = 1'b1;
    localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL = INTERVAL_BITS'(1);

    // Item operations
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_SAMPLE  = 1'b1;

    // Per-lane channel settings
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic                   rev;
    } t_lane_cfg;

    // Work issued to a lane on acceptance of a beat
    typedef struct packed {
        logic                   start;
        logic                   op;
        logic                   upd;
        logic [SAMPLE_BITS-1:0] raw;
        logic [STAMP_BITS-1:0]  dt;
    } t_lane_cmd;

    // Lane findings handed to the merge stage
    typedef struct packed {
        logic                done;
        logic [POS_BITS-1:0] pos;
        logic [POS_BITS-1:0] vel;
    } t_lane_res;

endpackage

[src/euv_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euv_if
// Valid/ready channels for sample beats in and result beats out.
// ---------------------------------------------------------------------------
interface euv_in_if;
    import euv_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [SAMPLE_BITS-1:0] raw_right;
    logic [SAMPLE_BITS-1:0] raw_left;
    logic [STAMP_BITS-1:0]  now_ms;

    modport source (output valid, operation, raw_right, raw_left, now_ms, input ready);
    modport sink   (input valid, operation, raw_right, raw_left, now_ms, output ready);
endinterface

interface euv_out_if;
    import euv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] pos_right;
    logic signed [POS_BITS-1:0] pos_left;
    logic signed [POS_BITS-1:0] vel_right;
    logic signed [POS_BITS-1:0] vel_left;
    logic                       vel_updated;

    modport source (output valid, pos_right, pos_left, vel_right, vel_left, vel_updated,
                    input ready);
    modport sink   (input valid, pos_right, pos_left, vel_right, vel_left, vel_updated,
                    output ready);
endinterface

[src/euv_vdiv.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euv_vdiv
// Restoring bit-serial divider for the velocity quotient,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module euv_vdiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [euv_pkg::MAG_W-1:0]         i_dividend,
    input  logic [euv_pkg::STAMP_BITS-1:0]    i_divisor,
    output logic                              o_done,
    output logic [euv_pkg::MAG_W-1:0]         o_quotient
);
    import euv_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [VDIV_CNT_W-1:0]  r_cnt;
    logic [MAG_W-1:0]       r_acc;
    logic [STAMP_BITS-1:0]  r_rem;
    logic [STAMP_BITS-1:0]  r_div;

    logic [STAMP_BITS:0]    w_trial;
    logic                   w_fit;
    logic                   w_last;

    // one compare-subtract step
    assign w_trial = {r_rem, r_acc[MAG_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});
    assign w_last  = (r_cnt == VDIV_CNT_W'(MAG_W - 1));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + VDIV_CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[MAG_W-2:0], w_fit};
            r_rem <= w_fit ? STAMP_BITS'(w_trial - {1'b0, r_div}) : STAMP_BITS'(w_trial);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_acc;

    // partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("euv_vdiv: remainder not below divisor");

endmodule

[src/euv_lane.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euv_lane
// One encoder channel: clamp and scale to a turn fraction, unwrap whole
// turns, form the displacement and, on request, the velocity.
// ---------------------------------------------------------------------------
module euv_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  euv_pkg::t_lane_cfg    i_cfg,
    input  euv_pkg::t_lane_cmd    i_cmd,
    output euv_pkg::t_lane_res    o_res
);
    import euv_pkg::*;

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_FRAC = 6'b000010,
        L_TURN = 6'b000100,
        L_POS  = 6'b001000,
        L_MUL  = 6'b010000,
        L_DIV  = 6'b100000
    } t_lane_state;

    localparam int DELTA_W = FRAC_W + 1;
    localparam int P_W     = TURN_BITS + FRACTION_BITS + 2;
    localparam int UP      = (FRACTION_BITS <= 16) ? 16 - FRACTION_BITS : 0;
    localparam int DN_RAW  = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
    localparam int DN      = (DN_RAW > 16) ? 16 : DN_RAW;
    localparam int Q_RAW   = P_W + UP + 1;
    localparam int Q_W     = (Q_RAW > POS_BITS) ? Q_RAW : POS_BITS + 1;

    localparam logic signed [DELTA_W-1:0]   HALF      = DELTA_W'(1 << (FRACTION_BITS - 1));
    localparam logic [FRAC_W-1:0]           FULL_TURN = FRAC_W'(1 << FRACTION_BITS);
    localparam logic signed [TURN_BITS-1:0] T_MAX     = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] T_MIN     = {1'b1, {(TURN_BITS-1){1'b0}}};
    localparam logic [POS_BITS-1:0]         P_MAX     = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic [POS_BITS-1:0]         P_MIN     = {1'b1, {(POS_BITS-1){1'b0}}};

    t_lane_state r_state, n_state;

    // channel state
    logic [FRAC_W-1:0]           r_start_frac;
    logic [FRAC_W-1:0]           r_prev_frac;
    logic signed [TURN_BITS-1:0] r_turns;
    logic [POS_BITS-1:0]         r_prev_pos;
    logic [POS_BITS-1:0]         r_vel;
    logic [POS_BITS-1:0]         r_pos;
    logic                        r_done;

    // item working registers
    logic                    r_op;
    logic                    r_upd;
    logic                    r_neg;
    logic [STAMP_BITS-1:0]   r_dt;
    logic [SAMPLE_BITS-1:0]  r_rem;
    logic [SAMPLE_BITS-1:0]  r_span;
    logic [FRAC_W-1:0]       r_quo;
    logic [FRAC_CNT_W-1:0]   r_cnt;

    logic [SAMPLE_BITS-1:0]    w_clamp;
    logic                      w_empty;
    logic [SAMPLE_BITS:0]      w_trial;
    logic                      w_fit;
    logic                      w_frac_last;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [P_W-1:0]     w_p;
    logic signed [Q_W-1:0]     w_q;
    logic signed [Q_W-1:0]     w_qs;
    logic                      w_fits;
    logic [POS_BITS-1:0]       w_pos_sat;
    logic signed [DIFF_W-1:0]  w_diff;
    logic [DIFF_W-1:0]         w_dmag;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [MAG_W-1:0]          w_div_quo;
    logic [POS_BITS-1:0]       w_vel_sat;

    // clamp to the channel limits; empty range yields fraction 0
    assign w_empty = (i_cfg.hi <= i_cfg.lo);
    assign w_clamp = (i_cmd.raw > i_cfg.hi) ? i_cfg.hi :
                     (i_cmd.raw < i_cfg.lo) ? i_cfg.lo : i_cmd.raw;

    // fraction divider step: first step decides the full-turn bit
    assign w_trial     = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_fit       = (w_trial >= {1'b0, r_span});
    assign w_frac_last = (r_cnt == FRAC_CNT_W'(FRAC_STEPS - 1));

    // jump against the previous fraction
    assign w_delta = $signed({1'b0, r_quo}) - $signed({1'b0, r_prev_frac});

    // displacement from start, scaled to Q16.16, sign applied, saturated
    assign w_p = P_W'($signed({r_turns, {FRACTION_BITS{1'b0}}}))
               + P_W'($signed({1'b0, r_quo}))
               - P_W'($signed({1'b0, r_start_frac}));
    assign w_q  = (Q_W'(w_p) <<< UP) >>> DN;
    assign w_qs = i_cfg.rev ? -w_q : w_q;
    assign w_fits = (&w_qs[Q_W-1:POS_BITS-1]) | ~(|w_qs[Q_W-1:POS_BITS-1]);
    assign w_pos_sat = w_fits ? POS_BITS'(w_qs) : (w_qs[Q_W-1] ? P_MIN : P_MAX);

    // |pos - prev| * 1000 for the divider
    assign w_diff = DIFF_W'($signed(r_pos)) - DIFF_W'($signed(r_prev_pos));
    assign w_dmag = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    assign w_mag  = {{(MAG_W-DIFF_W){1'b0}}, w_dmag} * MAG_W'(RATE_SCALE);
    assign w_div_start = (r_state == L_MUL) && (r_dt != '0);

    // quotient saturation, rounded toward zero
    always_comb begin
        if (!r_neg) begin
            w_vel_sat = ((|w_div_quo[MAG_W-1:POS_BITS-1])) ? P_MAX
                                                            : POS_BITS'(w_div_quo);
        end else if ((|w_div_quo[MAG_W-1:POS_BITS]) ||
                     (w_div_quo[POS_BITS-1] && (|w_div_quo[POS_BITS-2:0]))) begin
            w_vel_sat = P_MIN;
        end else begin
            w_vel_sat = POS_BITS'(-w_div_quo[POS_BITS-1:0]);
        end
    end

    euv_vdiv u_vdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_cmd.start) n_state = L_FRAC;
            L_FRAC: if (w_frac_last) n_state = L_TURN;
            L_TURN: n_state = (r_op == OP_CAPTURE) ? L_IDLE : L_POS;
            L_POS:  n_state = r_upd ? L_MUL : L_IDLE;
            L_MUL:  n_state = (r_dt != '0) ? L_DIV : L_IDLE;
            L_DIV:  if (w_div_done) n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    // control and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= L_IDLE;
            r_done       <= 1'b0;
            r_start_frac <= '0;
            r_prev_frac  <= '0;
            r_turns      <= '0;
            r_prev_pos   <= '0;
            r_vel        <= '0;
            r_pos        <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                L_TURN: begin
                    r_prev_frac <= r_quo;
                    if (r_op == OP_CAPTURE) begin
                        r_start_frac <= r_quo;
                        r_turns      <= '0;
                        r_prev_pos   <= '0;
                        r_pos        <= '0;
                        r_done       <= 1'b1;
                    end else if (w_delta > HALF) begin
                        if (r_turns > T_MIN) r_turns <= r_turns - TURN_BITS'(1);
                    end else if (w_delta < -HALF) begin
                        if (r_turns < T_MAX) r_turns <= r_turns + TURN_BITS'(1);
                    end
                end
                L_POS: begin
                    r_pos <= w_pos_sat;
                    if (!r_upd) r_done <= 1'b1;
                end
                L_MUL: begin
                    r_prev_pos <= r_pos;
                    if (r_dt == '0) begin
                        r_vel  <= '0;
                        r_done <= 1'b1;
                    end
                end
                L_DIV: begin
                    if (w_div_done) begin
                        r_vel  <= w_vel_sat;
                        r_done <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // item working registers
    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_cmd.start) begin
            r_op   <= i_cmd.op;
            r_upd  <= i_cmd.upd;
            r_dt   <= i_cmd.dt;
            r_rem  <= w_empty ? '0 : SAMPLE_BITS'(w_clamp - i_cfg.lo);
            r_span <= w_empty ? '1 : SAMPLE_BITS'(i_cfg.hi - i_cfg.lo);
            r_quo  <= '0;
            r_cnt  <= '0;
        end else if (r_state == L_FRAC) begin
            r_rem <= w_fit ? SAMPLE_BITS'(w_trial - {1'b0, r_span}) : SAMPLE_BITS'(w_trial);
            r_quo <= {r_quo[FRAC_W-2:0], w_fit};
            r_cnt <= r_cnt + FRAC_CNT_W'(1);
        end else if (r_state == L_MUL) begin
            r_neg <= w_diff[DIFF_W-1];
        end
    end

    assign o_res.done = r_done;
    assign o_res.pos  = r_pos;
    assign o_res.vel  = r_vel;

    // scaled fraction never exceeds one full turn
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_TURN) |-> (r_quo <= FULL_TURN))
        else $error("euv_lane: fraction above a full turn");

    // divider only finishes while the lane waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == L_DIV))
        else $error("euv_lane: divider result outside divide state");

endmodule

[src/encoder_unwrap_velocity.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_unwrap_velocity
// Two-lane turn unwrap and velocity for right and left absolute encoders,
// with APB register file, time-interval gate and result merge.
// ---------------------------------------------------------------------------
//  Port        Dir   Handshake            Beat
//  i_in        in    valid/ready          operation, raw samples, now_ms
//  o_out       out   valid/ready          positions, velocities, update flag
//  APB         in    psel/penable/pready  7 registers at 4*index
//
//  Capture beat: fraction divide and turn update; a sample without
//  velocity update adds the position step; with update it adds the 43-step
//  bit-serial velocity divider in each lane (both lanes run in lockstep).
//  One beat in flight; i_in.ready rises again once the result is in the
//  output register. A stalled output holds the lanes until it drains.
//  Reset is synchronous, active low, and clears all channel state.
// ---------------------------------------------------------------------------
module encoder_unwrap_velocity (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    euv_in_if.sink                        i_in,
    euv_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [euv_pkg::ADDR_W-1:0]    paddr,
    input  logic [euv_pkg::DATA_W-1:0]    pwdata,
    output logic [euv_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import euv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_BUSY = 3'b010,
        S_HOLD = 3'b100
    } t_top_state;

    t_top_state r_state, n_state;

    // configuration registers
    logic [SAMPLE_BITS-1:0]   r_lo_r, r_hi_r, r_lo_l, r_hi_l;
    logic                     r_rev_r, r_rev_l;
    logic [INTERVAL_BITS-1:0] r_min_iv;

    logic [STAMP_BITS-1:0] r_last_stamp;
    logic                  r_upd;

    // output register
    logic                r_ovalid;
    logic [POS_BITS-1:0] r_opos_r, r_opos_l, r_ovel_r, r_ovel_l;
    logic                r_oupd;

    logic                  w_acc;
    logic                  w_cfg_wr;
    t_reg_idx              w_idx;
    logic [STAMP_BITS-1:0] w_dt;
    logic                  w_upd;
    logic                  w_done;
    logic                  w_load;
    t_lane_cfg             w_cfg_r, w_cfg_l;
    t_lane_cmd             w_cmd_r, w_cmd_l;
    t_lane_res             w_res_r, w_res_l;

    // APB register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_r   <= RST_LOWER;
            r_hi_r   <= RST_UPPER;
            r_lo_l   <= RST_LOWER;
            r_hi_l   <= RST_UPPER;
            r_rev_r  <= RST_REV_RIGHT;
            r_rev_l  <= RST_REV_LEFT;
            r_min_iv <= RST_INTERVAL;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_LOWER_RIGHT:   r_lo_r   <= pwdata[SAMPLE_BITS-1:0];
                REG_UPPER_RIGHT:   r_hi_r   <= pwdata[SAMPLE_BITS-1:0];
                REG_LOWER_LEFT:    r_lo_l   <= pwdata[SAMPLE_BITS-1:0];
                REG_UPPER_LEFT:    r_hi_l   <= pwdata[SAMPLE_BITS-1:0];
                REG_REVERSE_RIGHT: r_rev_r  <= pwdata[0];
                REG_REVERSE_LEFT:  r_rev_l  <= pwdata[0];
                REG_MIN_INTERVAL:  r_min_iv <= pwdata[INTERVAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (w_idx)
            REG_LOWER_RIGHT:   prdata = DATA_W'(r_lo_r);
            REG_UPPER_RIGHT:   prdata = DATA_W'(r_hi_r);
            REG_LOWER_LEFT:    prdata = DATA_W'(r_lo_l);
            REG_UPPER_LEFT:    prdata = DATA_W'(r_hi_l);
            REG_REVERSE_RIGHT: prdata = DATA_W'(r_rev_r);
            REG_REVERSE_LEFT:  prdata = DATA_W'(r_rev_l);
            REG_MIN_INTERVAL:  prdata = DATA_W'(r_min_iv);
            default:           prdata = '0;
        endcase
    end

    // interval gate: elapsed ms modulo 2^32
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_dt       = i_in.now_ms - r_last_stamp;
    assign w_upd      = (i_in.operation == OP_SAMPLE) &&
                        (w_dt >= STAMP_BITS'(r_min_iv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_stamp <= '0;
        end else if (w_acc && (i_in.operation == OP_CAPTURE || w_upd)) begin
            r_last_stamp <= i_in.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_upd <= w_upd;
    end

    // lanes
    assign w_cfg_r = '{lo: r_lo_r, hi: r_hi_r, rev: r_rev_r};
    assign w_cfg_l = '{lo: r_lo_l, hi: r_hi_l, rev: r_rev_l};
    assign w_cmd_r = '{start: w_acc, op: i_in.operation, upd: w_upd,
                       raw: i_in.raw_right, dt: w_dt};
    assign w_cmd_l = '{start: w_acc, op: i_in.operation, upd: w_upd,
                       raw: i_in.raw_left, dt: w_dt};

    euv_lane u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg_r),
        .i_cmd   (w_cmd_r),
        .o_res   (w_res_r)
    );

    euv_lane u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg_l),
        .i_cmd   (w_cmd_l),
        .o_res   (w_res_l)
    );

    // merge: lanes finish together; results stay put until loaded
    assign w_done = w_res_r.done && w_res_l.done;
    assign w_load = ((r_state == S_BUSY && w_done) || r_state == S_HOLD) &&
                    (!r_ovalid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = S_BUSY;
            S_BUSY: if (w_done) n_state = w_load ? S_IDLE : S_HOLD;
            S_HOLD: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_opos_r <= w_res_r.pos;
            r_opos_l <= w_res_l.pos;
            r_ovel_r <= w_res_r.vel;
            r_ovel_l <= w_res_l.vel;
            r_oupd   <= r_upd;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.pos_right   = r_opos_r;
    assign o_out.pos_left    = r_opos_l;
    assign o_out.vel_right   = r_ovel_r;
    assign o_out.vel_left    = r_ovel_l;
    assign o_out.vel_updated = r_oupd;

    // capture beat restarts the velocity time base
    a_capture_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.operation == OP_CAPTURE) |=> (r_last_stamp == $past(i_in.now_ms)))
        else $error("top: capture did not record time stamp");

    // both lanes run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_r.done == w_res_l.done)
        else $error("top: lanes out of step");

    // lane results only arrive while a beat is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_BUSY))
        else $error("top: lane result with no beat in flight");

endmodule
